// ===== rtl/distance_vector_route_table_defines.svh =====
// Assertion macros for the distance-vector route table.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/drt_pkg.sv =====
// Shared types and codes for the distance-vector route table.
// No dependencies.
package drt_pkg;

  // Command codes
  localparam logic [2:0] CMD_LOAD      = 3'd0;
  localparam logic [2:0] CMD_UPD_BEGIN = 3'd1;
  localparam logic [2:0] CMD_UPD_ENTRY = 3'd2;
  localparam logic [2:0] CMD_TICK      = 3'd3;
  localparam logic [2:0] CMD_COMPOSE   = 3'd4;
  localparam logic [2:0] CMD_READ_CLR  = 3'd5;
  localparam logic [2:0] CMD_CLEAR     = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOSESSION = 2'd2;
  localparam logic [1:0] ST_UNREACH   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_INFINITY = 2'd0;
  localparam logic [1:0] REG_TTL      = 2'd1;
  localparam logic [1:0] REG_SPLIT    = 2'd2;

  localparam logic [31:0] INFINITY_RESET = 32'd65535;
  localparam logic [15:0] TTL_RESET      = 16'd90;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] peer_ip;
    logic [31:0] route_dest;
    logic [31:0] route_cost;
    logic        is_neighbor;
    logic        final_entry;
  } drt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] dest_ip;
    logic [31:0] adv_cost;
    logic        last;
    logic        changed;
  } drt_out_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] hop;
    logic [31:0] cost;
    logic [15:0] age;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_EMIT,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/drt_cell.sv =====
// One route-table cell of the rotating chain.
// Depends on drt_pkg.
module drt_cell
  import drt_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  // Take the neighbor's entry on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/distance_vector_route_table.sv =====
// Distance-vector route table. Entries sit in a ring of MAX_NODES cells that
// rotates one place per cycle past a single update unit at its head, during a
// pass and during an emit that the output does not stall. A command is accepted
// in idle, takes one full revolution of the ring, and then posts its result once
// the output can take it. A compose whose neighbor is reachable takes a second
// revolution that emits one result per occupied entry instead of the posting
// step, one per cycle while the output does not stall. The next command
// is accepted once the previous one is back in idle, while its result may
// still wait in the output register.
module distance_vector_route_table
  import drt_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  drt_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output drt_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  `include "distance_vector_route_table_defines.svh"

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_NODES - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_NODES);

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  drt_in_t       cmd_q;
  logic          changed_q, changed_d;
  logic [31:0]   speer_q, speer_d;
  logic [31:0]   scost_q, scost_d;
  logic          svalid_q, svalid_d;
  logic          found_q, found_d;
  logic          reach_q, reach_d;
  logic [31:0]   inf_q;
  logic [15:0]   ttl_q;
  logic          split_q;
  logic          out_valid_q, out_valid_d;
  drt_out_t      out_q, out_d;
  logic          shift;
  entry_t        ring [MAX_NODES];
  entry_t        head, proc;

  // Ring of cells; the head entry goes back in at the tail after processing
  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    entry_t nxt;
    if (k == MAX_NODES - 1) begin : g_tail
      assign nxt = proc;
    end else begin : g_mid
      assign nxt = ring[k+1];
    end
    drt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (ring[k])
    );
  end

  assign head = ring[0];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q   <= INFINITY_RESET;
      ttl_q   <= TTL_RESET;
      split_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INFINITY: inf_q   <= cfg_data_i;
        REG_TTL:      ttl_q   <= cfg_data_i[15:0];
        REG_SPLIT:    split_q <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      changed_q   <= 1'b0;
      speer_q     <= '0;
      scost_q     <= '0;
      svalid_q    <= 1'b0;
      found_q     <= 1'b0;
      reach_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      changed_q   <= changed_d;
      speer_q     <= speer_d;
      scost_q     <= scost_d;
      svalid_q    <= svalid_d;
      found_q     <= found_d;
      reach_q     <= reach_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q <= in_data_i;
    end
    out_q <= out_d;
  end

  // Head processing, sequencing and result posting
  always_comb begin
    logic        in_tab;
    logic        can_out;
    logic [31:0] cand;
    logic [31:0] c;
    in_tab      = ({1'b0, CW'(idx_q)} < {1'b0, count_q});
    can_out     = !out_valid_q || !out_stall_i;
    cand        = cmd_q.route_cost + scost_q;
    c           = head.cost;
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    changed_d   = changed_q;
    speer_d     = speer_q;
    scost_d     = scost_q;
    svalid_d    = svalid_q;
    found_d     = found_q;
    reach_d     = reach_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    proc        = head;
    shift       = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PASS;
          idx_d   = '0;
          found_d = 1'b0;
          reach_d = 1'b0;
        end
      end

      ST_PASS: begin
        shift = 1'b1;
        case (cmd_q.cmd)
          CMD_LOAD: begin
            if (CW'(idx_q) == count_q) begin
              proc.dest = cmd_q.route_dest;
              proc.age  = ttl_q;
              proc.hop  = cmd_q.is_neighbor ? cmd_q.route_dest : 32'd0;
              proc.cost = cmd_q.is_neighbor ? 32'd1 : inf_q;
            end
          end
          CMD_UPD_BEGIN: begin
            if (in_tab && !found_q && head.dest == cmd_q.peer_ip &&
                head.hop == cmd_q.peer_ip) begin
              proc.age = ttl_q;
              found_d  = 1'b1;
              scost_d  = head.cost;
              speer_d  = cmd_q.peer_ip;
            end
          end
          CMD_UPD_ENTRY: begin
            if (svalid_q && in_tab && head.dest == cmd_q.route_dest) begin
              if (head.cost > cand) begin
                proc.hop  = speer_q;
                proc.cost = cand;
                changed_d = 1'b1;
              end
              if (proc.hop == speer_q) begin
                proc.age = ttl_q;
              end
            end
          end
          CMD_TICK: begin
            if (in_tab && head.age != 16'd0) begin
              proc.age = head.age - 16'd1;
              if (head.age == 16'd1) begin
                proc.cost = inf_q;
                proc.hop  = 32'd0;
                changed_d = 1'b1;
              end
            end
          end
          CMD_COMPOSE: begin
            if (in_tab && !found_q && head.dest == cmd_q.peer_ip) begin
              found_d = 1'b1;
              reach_d = (head.cost < inf_q);
            end
          end
          default: ;
        endcase
        idx_d = idx_q + IW'(1);
        if (idx_q == IDX_LAST) begin
          idx_d = '0;
          if (cmd_q.cmd == CMD_COMPOSE && reach_d && count_q != '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_EMIT: begin
        if (can_out) begin
          shift = 1'b1;
          if (in_tab) begin
            if (split_q && head.hop == cmd_q.peer_ip) begin
              c = inf_q;
            end
            out_valid_d      = 1'b1;
            out_d.status     = ST_OK;
            out_d.dest_ip    = head.dest;
            out_d.adv_cost   = c;
            out_d.last       = ((CW'(idx_q) + CW'(1)) == count_q);
            out_d.changed    = changed_q;
          end
          idx_d = idx_q + IW'(1);
          if (idx_q == IDX_LAST) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end

      ST_DONE: begin
        if (can_out) begin
          out_valid_d    = 1'b1;
          out_d.status   = ST_OK;
          out_d.dest_ip  = 32'd0;
          out_d.adv_cost = 32'd0;
          out_d.last     = 1'b1;
          out_d.changed  = changed_q;
          state_d        = ST_IDLE;
          case (cmd_q.cmd)
            CMD_LOAD: begin
              if (count_q == CNT_MAX) begin
                out_d.status = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            CMD_UPD_BEGIN: begin
              svalid_d = found_q;
              if (!found_q) begin
                out_d.status = ST_NOSESSION;
              end
            end
            CMD_UPD_ENTRY: begin
              if (!svalid_q) begin
                out_d.status = ST_NOSESSION;
              end else if (cmd_q.final_entry) begin
                svalid_d = 1'b0;
              end
            end
            CMD_COMPOSE: begin
              if (!reach_q) begin
                out_d.status = ST_UNREACH;
              end
            end
            CMD_READ_CLR: changed_d = 1'b0;
            CMD_CLEAR: begin
              count_d  = '0;
              svalid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions
  `DRT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_MAX, "count beyond depth")
  `DRT_ASSERT_NEXT(a_accept_starts, state_q == ST_IDLE && in_valid_i, state_q == ST_PASS, "no pass")
  `DRT_ASSERT_NEXT(a_pass_runs, state_q == ST_PASS && idx_q != IDX_LAST, state_q == ST_PASS, "short")
  `DRT_ASSERT_NEXT(a_emit_ok, state_q == ST_EMIT && out_valid_d && !(out_valid_q && out_stall_i), out_q.status == ST_OK, "emit status")

endmodule
